### rtl/rgb_to_hsv_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSV assertion macros
// Shorthand for the concurrent checks on the rgb_to_hsv ports. Every check is
// clocked by clk and is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_MACROS_SVH
`define RGB_TO_HSV_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types and fixed constants of the color conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

	// Hue sector, picked by the first maximal channel in the order R, G, B.
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// Per-pixel flags that travel beside the divider stages.
	typedef struct packed {
		sector_t sector;
		logic    neg;
		logic    grey;
		logic    black;
	} hue_flags_t;

	// One hue sector is 60 degrees, the full circle 360 degrees.
	localparam int unsigned HUE_SECTOR_DEG = 60;
	localparam int unsigned HUE_CIRCLE_DEG = 360;
	// Integer bits needed for 60 (6 bits) and for 360 (9 bits).
	localparam int unsigned HUE_SECTOR_BITS = 6;
	localparam int unsigned HUE_CIRCLE_BITS = 9;

endpackage

### rtl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// RGB to HSV color conversion
// Two front stages, max(6 + HUE_FRAC_BITS, CHANNEL_BITS) divider stages and one
// result stage lie between request accept and result valid. Throughput: one
// pixel per cycle while the output is not stalled; the bit-per-stage dividers
// set the depth, not the rate. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
//
// Each pixel is split into max, min and a sector. The hue within the sector is
// |diff| * (60 << HUE_FRAC_BITS) / delta, truncated, which is the magnitude of
// a division that truncates toward zero; the sign is applied afterwards, the
// sector offset added and a negative hue wrapped by one full circle.
// Saturation is ((2^CHANNEL_BITS - 1) * delta) / max. Both divisions run in
// parallel restoring dividers that resolve one quotient bit per stage. The
// shorter one carries its quotient through extra stages so both line up.
//
// Grey pixels (delta zero) force the hue to zero and black pixels (max zero)
// force the saturation to zero, since the dividers then see a zero divisor.
//
// Flow control is a chained ready: a stage loads when it is empty or when the
// stage after it loads, so a new request is taken while a finished result still
// waits in the output register as long as some stage has a bubble.
module rgb_to_hsv import rth_pkg::*; #(
	parameter int unsigned CHANNEL_BITS  = 8,
	parameter int unsigned HUE_FRAC_BITS = 6
) (
	input  logic clk,
	input  logic arst_n,
	// Request side. s_tdata: red, green, blue (CHANNEL_BITS each), zero pad.
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          s_tdata,
	// Result side. m_tdata: hue (HUE_CIRCLE_BITS + HUE_FRAC_BITS bits),
	// saturation, brightness (CHANNEL_BITS each), zero pad.
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	output logic [((HUE_CIRCLE_BITS+HUE_FRAC_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned HUE_W  = HUE_CIRCLE_BITS + HUE_FRAC_BITS;
	localparam int unsigned HQ_W   = HUE_SECTOR_BITS + HUE_FRAC_BITS;
	localparam int unsigned HNUM_W = CHANNEL_BITS + HQ_W;
	localparam int unsigned OUT_W  = ((HUE_W + 2*CHANNEL_BITS + 7) / 8) * 8;
	localparam int unsigned DIV_ST = (HQ_W > CHANNEL_BITS) ? HQ_W : CHANNEL_BITS;
	// Front stages, divider stages, result stage.
	localparam int unsigned DEPTH  = DIV_ST + 3;

	// Hue arithmetic runs one bit wider than the field to see the sign.
	localparam logic [HUE_W:0] OFS_GREEN =
		(HUE_W+1)'(2 * HUE_SECTOR_DEG) << HUE_FRAC_BITS;
	localparam logic [HUE_W:0] OFS_BLUE  =
		(HUE_W+1)'(4 * HUE_SECTOR_DEG) << HUE_FRAC_BITS;
	localparam logic [HUE_W:0] HUE_FULL  =
		(HUE_W+1)'(HUE_CIRCLE_DEG) << HUE_FRAC_BITS;

	logic [DEPTH-1:0] load;

	logic [CHANNEL_BITS-1:0]   delta_s2, max_s2;
	logic [HNUM_W-1:0]         hue_num_s2;
	logic [2*CHANNEL_BITS-1:0] sat_num_s2;
	hue_flags_t                flags_s2;

	// Sideband that travels beside the divider stages.
	hue_flags_t              flags_sd  [DIV_ST];
	logic [CHANNEL_BITS-1:0] bright_sd [DIV_ST];

	logic [HQ_W-1:0]         hue_quo;
	logic [CHANNEL_BITS-1:0] sat_quo;

	logic [HUE_W:0]          hue_base, hue_sum, hue_wrap;
	hue_flags_t              flags_last;

	logic [HUE_W-1:0]        hue_s3;
	logic [CHANNEL_BITS-1:0] sat_s3, bright_s3;

	rth_pipe_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.load      (load),
		.out_valid (m_tvalid)
	);

	rth_front #(
		.CHANNEL_BITS  (CHANNEL_BITS),
		.HUE_FRAC_BITS (HUE_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.load       (load[1:0]),
		.red        (s_tdata[CHANNEL_BITS-1:0]),
		.green      (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
		.blue       (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
		.delta_s2   (delta_s2),
		.max_s2     (max_s2),
		.hue_num_s2 (hue_num_s2),
		.sat_num_s2 (sat_num_s2),
		.flags_s2   (flags_s2)
	);

	// Hue magnitude: quotient never exceeds one sector step.
	rth_divider #(
		.NUM_W  (HNUM_W),
		.DEN_W  (CHANNEL_BITS),
		.QUO_W  (HQ_W),
		.STAGES (DIV_ST)
	) u_hue_div (
		.clk  (clk),
		.load (load[DIV_ST+1:2]),
		.num  (hue_num_s2),
		.den  (delta_s2),
		.quo  (hue_quo)
	);

	// Saturation: delta never exceeds max, so the quotient fits a channel.
	rth_divider #(
		.NUM_W  (2*CHANNEL_BITS),
		.DEN_W  (CHANNEL_BITS),
		.QUO_W  (CHANNEL_BITS),
		.STAGES (DIV_ST)
	) u_sat_div (
		.clk  (clk),
		.load (load[DIV_ST+1:2]),
		.num  (sat_num_s2),
		.den  (max_s2),
		.quo  (sat_quo)
	);

	for (genvar j = 0; j < DIV_ST; j++) begin : g_side
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (load[2]) begin
					flags_sd[0]  <= flags_s2;
					bright_sd[0] <= max_s2;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (load[j+2]) begin
					flags_sd[j]  <= flags_sd[j-1];
					bright_sd[j] <= bright_sd[j-1];
				end
			end
		end
	end

	assign flags_last = flags_sd[DIV_ST-1];

	// Signed hue within the sector, sector offset and wrap into one circle.
	always_comb begin
		unique case (flags_last.sector)
			SECT_RED:   hue_base = '0;
			SECT_GREEN: hue_base = OFS_GREEN;
			SECT_BLUE:  hue_base = OFS_BLUE;
			default:    hue_base = '0;
		endcase
		hue_sum  = flags_last.neg ? hue_base - {(HUE_W+1-HQ_W)'(0), hue_quo}
		                          : hue_base + {(HUE_W+1-HQ_W)'(0), hue_quo};
		hue_wrap = hue_sum[HUE_W] ? hue_sum + HUE_FULL : hue_sum;
	end

	always_ff @(posedge clk) begin
		if (load[DEPTH-1]) begin
			hue_s3    <= flags_last.grey  ? '0 : hue_wrap[HUE_W-1:0];
			sat_s3    <= flags_last.black ? '0 : sat_quo;
			bright_s3 <= bright_sd[DIV_ST-1];
		end
	end

	assign m_tdata = OUT_W'({bright_s3, sat_s3, hue_s3});

endmodule

### rtl/rth_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two register stages: channel max, min and sector, then delta and the two
// dividends for the hue and saturation dividers.
// ----------------------------------------------------------------------------
module rth_front import rth_pkg::*; #(
	parameter int unsigned CHANNEL_BITS  = 8,
	parameter int unsigned HUE_FRAC_BITS = 6
) (
	input  logic                                       clk,
	input  logic [1:0]                                 load,
	input  logic [CHANNEL_BITS-1:0]                    red,
	input  logic [CHANNEL_BITS-1:0]                    green,
	input  logic [CHANNEL_BITS-1:0]                    blue,
	output logic [CHANNEL_BITS-1:0]                    delta_s2,
	output logic [CHANNEL_BITS-1:0]                    max_s2,
	output logic [CHANNEL_BITS+HUE_SECTOR_BITS+HUE_FRAC_BITS-1:0] hue_num_s2,
	output logic [2*CHANNEL_BITS-1:0]                  sat_num_s2,
	output hue_flags_t                                 flags_s2
);

	localparam int unsigned HQ_W   = HUE_SECTOR_BITS + HUE_FRAC_BITS;
	localparam logic [HQ_W-1:0] HUE_STEP = HQ_W'(HUE_SECTOR_DEG) << HUE_FRAC_BITS;

	logic [CHANNEL_BITS-1:0] max_c, min_c, dif_a, dif_b;
	sector_t                 sector_c;

	logic [CHANNEL_BITS-1:0] max_s1, min_s1, mag_s1;
	sector_t                 sector_s1;
	logic                    neg_s1;

	logic [CHANNEL_BITS-1:0] delta_c;

	// Stage 1: sector choice and the signed channel difference of that sector.
	always_comb begin
		if (red >= green && red >= blue) begin
			sector_c = SECT_RED;
			max_c    = red;
			dif_a    = green;
			dif_b    = blue;
		end else if (green >= blue) begin
			sector_c = SECT_GREEN;
			max_c    = green;
			dif_a    = blue;
			dif_b    = red;
		end else begin
			sector_c = SECT_BLUE;
			max_c    = blue;
			dif_a    = red;
			dif_b    = green;
		end
		if (red <= green && red <= blue) begin
			min_c = red;
		end else if (green <= blue) begin
			min_c = green;
		end else begin
			min_c = blue;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			max_s1    <= max_c;
			min_s1    <= min_c;
			sector_s1 <= sector_c;
			neg_s1    <= dif_a < dif_b;
			mag_s1    <= (dif_a < dif_b) ? dif_b - dif_a : dif_a - dif_b;
		end
	end

	// Stage 2: delta, the hue dividend |diff| * step and (2^N - 1) * delta.
	assign delta_c = max_s1 - min_s1;

	always_ff @(posedge clk) begin
		if (load[1]) begin
			delta_s2       <= delta_c;
			max_s2         <= max_s1;
			hue_num_s2     <= {HQ_W'(0), mag_s1} * {CHANNEL_BITS'(0), HUE_STEP};
			sat_num_s2     <= {delta_c, CHANNEL_BITS'(0)} - {CHANNEL_BITS'(0), delta_c};
			flags_s2.sector <= sector_s1;
			flags_s2.neg    <= neg_s1;
			flags_s2.grey   <= delta_c == '0;
			flags_s2.black  <= max_s1 == '0;
		end
	end

endmodule

### rtl/rth_divider.sv
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, one quotient bit per register stage, most significant
// bit first. Stages past the quotient width only carry the quotient along.
// The quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module rth_divider #(
	parameter int unsigned NUM_W  = 20,
	parameter int unsigned DEN_W  = 8,
	parameter int unsigned QUO_W  = 12,
	parameter int unsigned STAGES = 12
) (
	input  logic              clk,
	input  logic [STAGES-1:0] load,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [QUO_W-1:0]  quo
);

	logic [NUM_W-1:0] rem_sd [STAGES];
	logic [DEN_W-1:0] den_sd [STAGES];
	logic [QUO_W-1:0] quo_sd [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sd[j-1];
			assign den_in = den_sd[j-1];
			assign quo_in = quo_sd[j-1];
		end

		if (j < QUO_W) begin : g_div
			localparam int BIT = int'(QUO_W) - 1 - j;

			logic [NUM_W:0] trial;

			// A set top bit means the shifted divisor did not fit.
			assign trial = {1'b0, rem_in} - ({(NUM_W+1-DEN_W)'(0), den_in} << BIT);

			always_ff @(posedge clk) begin
				if (load[j]) begin
					rem_sd[j] <= trial[NUM_W] ? rem_in : trial[NUM_W-1:0];
					den_sd[j] <= den_in;
					quo_sd[j] <= {quo_in[QUO_W-2:0], ~trial[NUM_W]};
				end
			end
		end else begin : g_carry
			always_ff @(posedge clk) begin
				if (load[j]) begin
					rem_sd[j] <= rem_in;
					den_sd[j] <= den_in;
					quo_sd[j] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_sd[STAGES-1];

endmodule

### rtl/rth_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// RGB to HSV pipeline control
// Valid bit per stage and the load enables. A stage loads when it is empty or
// when the stage after it loads, so bubbles are squeezed out under a stall.
// ----------------------------------------------------------------------------
module rth_pipe_ctrl #(
	parameter int unsigned DEPTH = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_ready,
	output logic             in_ready,
	output logic [DEPTH-1:0] load,
	output logic             out_valid
);

	logic [DEPTH-1:0] stage_valid_q;
	logic [DEPTH-1:0] valid_in;

	assign load[DEPTH-1] = !stage_valid_q[DEPTH-1] || out_ready;

	for (genvar k = 0; k < DEPTH - 1; k++) begin : g_load
		assign load[k] = !stage_valid_q[k] || load[k+1];
	end

	// Each stage takes the valid bit of the stage before it.
	assign valid_in = {stage_valid_q[DEPTH-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (load[k]) begin
					stage_valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = stage_valid_q[DEPTH-1];

endmodule

### rtl/rgb_to_hsv_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Concurrent checks on the ports of rgb_to_hsv, bound to every instance.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_macros.svh"

module rgb_to_hsv_checker import rth_pkg::*; #(
	parameter int unsigned CHANNEL_BITS  = 8,
	parameter int unsigned HUE_FRAC_BITS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((HUE_CIRCLE_BITS+HUE_FRAC_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned HUE_W = HUE_CIRCLE_BITS + HUE_FRAC_BITS;
	localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(HUE_CIRCLE_DEG) << HUE_FRAC_BITS;

	logic [HUE_W-1:0]        hue;
	logic [CHANNEL_BITS-1:0] sat, bright;

	assign hue    = m_tdata[HUE_W-1:0];
	assign sat    = m_tdata[HUE_W+CHANNEL_BITS-1:HUE_W];
	assign bright = m_tdata[HUE_W+2*CHANNEL_BITS-1:HUE_W+CHANNEL_BITS];

	// A held result stays put until it is taken.
	`RTH_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// An empty output register means every stage can move.
	`RTH_ASSERT_SAME(a_ready, !m_tvalid, s_tready, "request refused with empty output")

	// The wrap keeps the hue inside one circle.
	`RTH_ASSERT_SAME(a_hue_range, m_tvalid, hue < HUE_FULL, "hue outside the circle")

	// Black pixels carry neither saturation nor hue.
	`RTH_ASSERT_SAME(a_black, m_tvalid && bright == '0, sat == '0 && hue == '0, "black pixel not zero")

	// Any hue means delta is nonzero, and then saturation is at least one.
	`RTH_ASSERT_SAME(a_tint, m_tvalid && hue != '0, sat != '0, "hue without saturation")

endmodule

bind rgb_to_hsv rgb_to_hsv_checker #(
	.CHANNEL_BITS  (CHANNEL_BITS),
	.HUE_FRAC_BITS (HUE_FRAC_BITS)
) u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
